/* src/qtf_pkg.sv */
// Package with the point and result types, sizes and the sequencer microcode of the fit.
`default_nettype none
package qtf_pkg;

    localparam int WORD_W    = 192;
    localparam int LIMBS     = 6;
    localparam int NUM_SLOTS = 32;
    localparam int PC_W      = 8;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] stamp;
        logic               final_point;
    } qtf_point_t;

    typedef struct packed {
        logic signed [31:0] fit_x;
        logic signed [31:0] fit_y;
        logic signed [31:0] fit_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] fit_time;
        logic               fit_error;
    } qtf_result_t;

    typedef enum logic [3:0] {
        OP_LD,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CHK,
        OP_ENDA,
        OP_ENDC
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] dst;
        logic [4:0] src_a;
        logic [4:0] src_b;
    } instr_t;

    // Load selector codes, carried in src_a of a load.
    localparam logic [4:0] LS_ZERO   = 5'd0;
    localparam logic [4:0] LS_ONE    = 5'd1;
    localparam logic [4:0] LS_V      = 5'd2;
    localparam logic [4:0] LS_X      = 5'd3;
    localparam logic [4:0] LS_Y      = 5'd4;
    localparam logic [4:0] LS_Z      = 5'd5;
    localparam logic [4:0] LS_N      = 5'd6;
    localparam logic [4:0] LS_K2     = 5'd7;
    localparam logic [4:0] LS_K3     = 5'd8;
    localparam logic [4:0] LS_K4     = 5'd9;
    localparam logic [4:0] LS_K6     = 5'd10;
    localparam logic [4:0] LS_K16384 = 5'd11;

    // Register file slots.
    localparam logic [4:0] R_S0   = 5'd0;
    localparam logic [4:0] R_S1   = 5'd1;
    localparam logic [4:0] R_S2   = 5'd2;
    localparam logic [4:0] R_S3   = 5'd3;
    localparam logic [4:0] R_S4   = 5'd4;
    localparam logic [4:0] R_T0   = 5'd5;
    localparam logic [4:0] R_N    = 5'd14;
    localparam logic [4:0] R_N2   = 5'd15;
    localparam logic [4:0] R_N3   = 5'd16;
    localparam logic [4:0] R_S1SQ = 5'd17;
    localparam logic [4:0] R_NS1  = 5'd18;
    localparam logic [4:0] R_A    = 5'd19;
    localparam logic [4:0] R_B3   = 5'd20;
    localparam logic [4:0] R_C4   = 5'd21;
    localparam logic [4:0] R_AA   = 5'd22;
    localparam logic [4:0] R_KK   = 5'd23;
    localparam logic [4:0] R_AK   = 5'd24;
    localparam logic [4:0] R_NK   = 5'd25;
    localparam logic [4:0] R_T    = 5'd26;
    localparam logic [4:0] R_U    = 5'd27;
    localparam logic [4:0] R_K    = 5'd28;
    localparam logic [4:0] R_Y1   = 5'd29;
    localparam logic [4:0] R_Y2   = 5'd30;
    localparam logic [4:0] R_G    = 5'd31;

    // Output register indexes for divisions.
    localparam logic [4:0] O_MEAN = 5'd6;

    localparam logic [PC_W-1:0] ACC_PC    = 8'd0;
    localparam logic [PC_W-1:0] SOLVE_PC  = 8'd29;
    localparam logic [PC_W-1:0] AXIS_PC   = 8'd70;
    localparam logic [PC_W-1:0] AXIS_LEN  = 8'd25;
    localparam logic [PC_W-1:0] MEAN_PC   = 8'd145;
    localparam logic [PC_W-1:0] CLEAR_PC  = 8'd148;
    localparam logic [PC_W-1:0] CLEAR_END = 8'd161;

    function automatic instr_t mk(input op_t op, input logic [4:0] d, input logic [4:0] a,
                                  input logic [4:0] b);
        instr_t r;
        r.op    = op;
        r.dst   = d;
        r.src_a = a;
        r.src_b = b;
        return r;
    endfunction

    // Accumulation of one point into the sums of one axis.
    function automatic instr_t acc_axis(input logic [1:0] ax, input logic [2:0] k);
        logic [4:0] t0;
        logic [4:0] sel;
        instr_t     r;
        t0  = 5'(R_T0 + 3 * ax);
        sel = 5'(LS_X + ax);
        case (k)
            3'd0:    r = mk(OP_LD,  R_T, sel, R_S0);
            3'd1:    r = mk(OP_ADD, t0, t0, R_T);
            3'd2:    r = mk(OP_MUL, R_U, R_T, R_N);
            3'd3:    r = mk(OP_ADD, 5'(t0 + 1), 5'(t0 + 1), R_U);
            3'd4:    r = mk(OP_MUL, R_U, R_T, R_N2);
            3'd5:    r = mk(OP_ADD, 5'(t0 + 2), 5'(t0 + 2), R_U);
            default: r = mk(OP_ENDA, R_S0, R_S0, R_S0);
        endcase
        return r;
    endfunction

    // Solve steps of one axis: position and velocity numerators and their divisions.
    function automatic instr_t solve_axis(input logic [1:0] ax, input logic [4:0] k);
        logic [4:0] t0;
        logic [4:0] t1;
        logic [4:0] t2;
        logic [4:0] po;
        logic [4:0] vo;
        instr_t     r;
        t0 = 5'(R_T0 + 3 * ax);
        t1 = 5'(t0 + 1);
        t2 = 5'(t0 + 2);
        po = 5'(ax);
        vo = 5'(ax + 3);
        case (k)
            5'd0:    r = mk(OP_MUL, R_T, R_N, t1);
            5'd1:    r = mk(OP_MUL, R_U, R_S1, t0);
            5'd2:    r = mk(OP_SUB, R_Y1, R_T, R_U);
            5'd3:    r = mk(OP_MUL, R_T, R_N2, t2);
            5'd4:    r = mk(OP_MUL, R_U, R_NS1, t1);
            5'd5:    r = mk(OP_LD,  R_K, LS_K2, R_S0);
            5'd6:    r = mk(OP_MUL, R_U, R_U, R_K);
            5'd7:    r = mk(OP_SUB, R_T, R_T, R_U);
            5'd8:    r = mk(OP_MUL, R_U, R_S1SQ, t0);
            5'd9:    r = mk(OP_ADD, R_Y2, R_T, R_U);
            5'd10:   r = mk(OP_MUL, R_T, R_A, R_Y2);
            5'd11:   r = mk(OP_MUL, R_U, R_AA, t0);
            5'd12:   r = mk(OP_SUB, R_T, R_T, R_U);
            5'd13:   r = mk(OP_MUL, R_U, R_B3, R_Y1);
            5'd14:   r = mk(OP_SUB, R_G, R_T, R_U);
            5'd15:   r = mk(OP_MUL, R_T, t0, R_KK);
            5'd16:   r = mk(OP_MUL, R_U, R_A, R_G);
            5'd17:   r = mk(OP_SUB, R_T, R_T, R_U);
            5'd18:   r = mk(OP_DIV, po, R_T, R_NK);
            5'd19:   r = mk(OP_MUL, R_T, R_Y1, R_KK);
            5'd20:   r = mk(OP_MUL, R_U, R_B3, R_G);
            5'd21:   r = mk(OP_SUB, R_T, R_T, R_U);
            5'd22:   r = mk(OP_LD,  R_K, LS_K16384, R_S0);
            5'd23:   r = mk(OP_MUL, R_T, R_T, R_K);
            5'd24:   r = mk(OP_DIV, vo, R_T, R_AK);
            default: r = mk(OP_ENDC, R_S0, R_S0, R_S0);
        endcase
        return r;
    endfunction

    function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] off;
        instr_t          r;
        r = mk(OP_ENDC, R_S0, R_S0, R_S0);
        if (pc >= 8'd10 && pc < SOLVE_PC - 8'd1) begin
            off = pc - 8'd10;
            if (off < 8'd6) begin
                r = acc_axis(2'd0, off[2:0]);
            end else if (off < 8'd12) begin
                r = acc_axis(2'd1, 3'(off - 8'd6));
            end else begin
                r = acc_axis(2'd2, 3'(off - 8'd12));
            end
        end else if (pc >= AXIS_PC && pc < MEAN_PC) begin
            off = pc - AXIS_PC;
            if (off < AXIS_LEN) begin
                r = solve_axis(2'd0, off[4:0]);
            end else if (off < 8'd2 * AXIS_LEN) begin
                r = solve_axis(2'd1, 5'(off - AXIS_LEN));
            end else begin
                r = solve_axis(2'd2, 5'(off - 8'd2 * AXIS_LEN));
            end
        end else if (pc >= CLEAR_PC && pc <= CLEAR_END) begin
            r = mk(OP_LD, 5'(pc - CLEAR_PC), LS_ZERO, R_S0);
        end else begin
            case (pc)
                8'd0:    r = mk(OP_LD,  R_K, LS_ONE, R_S0);
                8'd1:    r = mk(OP_ADD, R_S0, R_S0, R_K);
                8'd2:    r = mk(OP_LD,  R_N, LS_V, R_S0);
                8'd3:    r = mk(OP_ADD, R_S1, R_S1, R_N);
                8'd4:    r = mk(OP_MUL, R_N2, R_N, R_N);
                8'd5:    r = mk(OP_ADD, R_S2, R_S2, R_N2);
                8'd6:    r = mk(OP_MUL, R_N3, R_N2, R_N);
                8'd7:    r = mk(OP_ADD, R_S3, R_S3, R_N3);
                8'd8:    r = mk(OP_MUL, R_U, R_N3, R_N);
                8'd9:    r = mk(OP_ADD, R_S4, R_S4, R_U);
                8'd28:   r = mk(OP_ENDA, R_S0, R_S0, R_S0);
                8'd29:   r = mk(OP_LD,  R_N, LS_N, R_S0);
                8'd30:   r = mk(OP_MUL, R_N2, R_N, R_N);
                8'd31:   r = mk(OP_MUL, R_N3, R_N2, R_N);
                8'd32:   r = mk(OP_MUL, R_S1SQ, R_S1, R_S1);
                8'd33:   r = mk(OP_MUL, R_T, R_N, R_S2);
                8'd34:   r = mk(OP_SUB, R_A, R_T, R_S1SQ);
                8'd35:   r = mk(OP_MUL, R_NS1, R_N, R_S1);
                8'd36:   r = mk(OP_MUL, R_T, R_N2, R_S3);
                8'd37:   r = mk(OP_MUL, R_U, R_NS1, R_S2);
                8'd38:   r = mk(OP_LD,  R_K, LS_K3, R_S0);
                8'd39:   r = mk(OP_MUL, R_U, R_U, R_K);
                8'd40:   r = mk(OP_SUB, R_T, R_T, R_U);
                8'd41:   r = mk(OP_MUL, R_U, R_S1SQ, R_S1);
                8'd42:   r = mk(OP_LD,  R_K, LS_K2, R_S0);
                8'd43:   r = mk(OP_MUL, R_U, R_U, R_K);
                8'd44:   r = mk(OP_ADD, R_B3, R_T, R_U);
                8'd45:   r = mk(OP_MUL, R_T, R_N3, R_S4);
                8'd46:   r = mk(OP_MUL, R_U, R_N2, R_S1);
                8'd47:   r = mk(OP_MUL, R_U, R_U, R_S3);
                8'd48:   r = mk(OP_LD,  R_K, LS_K4, R_S0);
                8'd49:   r = mk(OP_MUL, R_U, R_U, R_K);
                8'd50:   r = mk(OP_SUB, R_T, R_T, R_U);
                8'd51:   r = mk(OP_MUL, R_U, R_N, R_S1SQ);
                8'd52:   r = mk(OP_MUL, R_U, R_U, R_S2);
                8'd53:   r = mk(OP_LD,  R_K, LS_K6, R_S0);
                8'd54:   r = mk(OP_MUL, R_U, R_U, R_K);
                8'd55:   r = mk(OP_ADD, R_T, R_T, R_U);
                8'd56:   r = mk(OP_MUL, R_U, R_S1SQ, R_S1SQ);
                8'd57:   r = mk(OP_LD,  R_K, LS_K3, R_S0);
                8'd58:   r = mk(OP_MUL, R_U, R_U, R_K);
                8'd59:   r = mk(OP_SUB, R_C4, R_T, R_U);
                8'd60:   r = mk(OP_MUL, R_AA, R_A, R_A);
                8'd61:   r = mk(OP_MUL, R_T, R_A, R_C4);
                8'd62:   r = mk(OP_MUL, R_U, R_AA, R_A);
                8'd63:   r = mk(OP_SUB, R_T, R_T, R_U);
                8'd64:   r = mk(OP_MUL, R_U, R_B3, R_B3);
                8'd65:   r = mk(OP_SUB, R_KK, R_T, R_U);
                8'd66:   r = mk(OP_CHK, R_S0, R_A, R_S0);
                8'd67:   r = mk(OP_CHK, R_S0, R_KK, R_S0);
                8'd68:   r = mk(OP_MUL, R_AK, R_A, R_KK);
                8'd69:   r = mk(OP_MUL, R_NK, R_N, R_KK);
                8'd145:  r = mk(OP_LD,  R_K, LS_K4, R_S0);
                8'd146:  r = mk(OP_MUL, R_T, R_S1, R_K);
                8'd147:  r = mk(OP_DIV, O_MEAN, R_T, R_N);
                default: r = mk(OP_ENDC, R_S0, R_S0, R_S0);
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/qtf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module qtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/quadratic_trajectory_fit.sv */
// Top level of the quadratic trajectory fit: microcoded sequencer around one shared 32x32
// multiplier, one shared 193-bit adder and a slot register file.
//
//   channel   handshake              payload          direction
//   point     start / busy           qtf_point_t      in
//   result    done (one-cycle pulse) qtf_result_t     out
//
// A kept point holds busy while it runs nine 192-bit multiplies on the shared 32x32
// multiplier, nineteen loads and adds and one end step; a dropped point that is not final
// leaves busy low.
// A final point adds 68 multiplies, seven restoring divisions and 44 other steps,
// then a 14-slot clear of the sums; done pulses as busy drops.
// After reset the block runs that 14-slot clear with busy high.
// The receiver cannot stall: a result is valid in the cycle that done is high and is held until the next result.
`default_nettype none
module quadratic_trajectory_fit
    import qtf_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire qtf_point_t  point,
    output logic             done,
    output qtf_result_t      result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_OPB,
        S_MUL,
        S_MULD,
        S_DIV,
        S_WB
    } state_t;

    localparam int AW = $clog2(NUM_SLOTS);

    state_t              state_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [4:0]          count_reg;
    logic                ovf_reg;
    logic                fail_reg;
    logic                final_reg;
    logic                done_reg;
    logic [31:0]         first_stamp_reg;
    logic [31:0]         x_reg;
    logic [31:0]         y_reg;
    logic [31:0]         z_reg;
    logic [12:0]         v_reg;
    logic [WORD_W-1:0]   a_reg;
    logic [WORD_W-1:0]   b_reg;
    logic [WORD_W-1:0]   res_reg;
    logic [WORD_W-1:0]   rem_reg;
    logic [31:0]         q_reg;
    logic                hi_reg;
    logic                neg_reg;
    logic [63:0]         pp_reg;
    logic [2:0]          pp_sh_reg;
    logic                pp_vld_reg;
    logic [2:0]          i_reg;
    logic [2:0]          j_reg;
    logic [7:0]          cnt_reg;
    logic [31:0]         out_reg [7];
    qtf_result_t         result_reg;

    instr_t              ins;
    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   ld_val;
    logic [WORD_W:0]     add_x;
    logic [WORD_W:0]     add_y;
    logic                add_cin;
    logic [WORD_W:0]     sum;
    logic [WORD_W-1:0]   a_dbl;
    logic [WORD_W-1:0]   den2;
    logic [WORD_W-1:0]   rem_sh;
    logic [WORD_W-1:0]   pp_shift;
    logic [31:0]         a_limb;
    logic [31:0]         b_limb;
    logic                mul_wrap;
    logic [31:0]         fs_sel;
    logic signed [32:0]  rel;
    logic                drop;
    logic [31:0]         q_lim;
    logic [31:0]         div_out;
    logic [32:0]         tsum;
    logic [31:0]         time_sat;
    qtf_result_t         result_next;
    logic                fit_err;

    assign ins = prog_rom(pc_reg);

    qtf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ins.dst),
        .wdata (res_reg),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign ram_raddr = (state_reg == S_RDB) ? ins.src_b : ins.src_a;
    assign ram_we    = (state_reg == S_WB) && (ins.op == OP_LD || ins.op == OP_ADD ||
                                               ins.op == OP_SUB || ins.op == OP_MUL);

    // Front end: relative time and the drop test for an offered point.
    assign fs_sel = (count_reg == 5'd0) ? point.stamp : first_stamp_reg;
    assign rel    = {point.stamp[31], point.stamp} - {fs_sel[31], fs_sel};
    assign drop   = (count_reg >= 5'(MAX_POINTS)) || rel[32] || (|rel[31:15]);

    always_comb
    begin
        case (ins.src_a)
            LS_ZERO:   ld_val = '0;
            LS_ONE:    ld_val = WORD_W'(1);
            LS_V:      ld_val = WORD_W'(v_reg);
            LS_X:      ld_val = {{(WORD_W-32){x_reg[31]}}, x_reg};
            LS_Y:      ld_val = {{(WORD_W-32){y_reg[31]}}, y_reg};
            LS_Z:      ld_val = {{(WORD_W-32){z_reg[31]}}, z_reg};
            LS_N:      ld_val = WORD_W'(count_reg);
            LS_K2:     ld_val = WORD_W'(2);
            LS_K3:     ld_val = WORD_W'(3);
            LS_K4:     ld_val = WORD_W'(4);
            LS_K6:     ld_val = WORD_W'(6);
            LS_K16384: ld_val = WORD_W'(16384);
            default:   ld_val = '0;
        endcase
    end

    assign a_dbl    = {a_reg[WORD_W-2:0], 1'b0};
    assign den2     = {b_reg[WORD_W-2:0], 1'b0};
    assign rem_sh   = {rem_reg[WORD_W-2:0], res_reg[WORD_W-1]};
    assign pp_shift = WORD_W'(pp_reg) << {pp_sh_reg, 5'b0};
    assign a_limb   = a_reg[32*i_reg +: 32];
    assign b_limb   = b_reg[32*j_reg +: 32];
    assign mul_wrap = ({1'b0, i_reg} + {1'b0, j_reg}) == 4'(LIMBS - 1);

    // Shared adder input selection.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_cin = 1'b0;
        case (state_reg)
            S_OPB:
            begin
                if (ins.op == OP_DIV)
                begin
                    // 2|num| + den, written as den - 2num when num is negative.
                    add_x   = {1'b0, rdata};
                    add_y   = a_reg[WORD_W-1] ? {1'b0, ~a_dbl} : {1'b0, a_dbl};
                    add_cin = a_reg[WORD_W-1];
                end
                else
                begin
                    add_x   = {1'b0, a_reg};
                    add_y   = (ins.op == OP_SUB) ? {1'b0, ~rdata} : {1'b0, rdata};
                    add_cin = (ins.op == OP_SUB);
                end
            end
            S_MUL, S_MULD:
            begin
                add_x = {1'b0, res_reg};
                add_y = {1'b0, pp_shift};
            end
            S_DIV:
            begin
                add_x   = {1'b0, rem_sh};
                add_y   = {1'b1, ~den2};
                add_cin = 1'b1;
            end
            default:
            begin
                add_x = '0;
            end
        endcase
    end

    assign sum = add_x + add_y + (WORD_W+1)'(add_cin);

    // Rounded quotient, saturated to the signed 32-bit range.
    assign q_lim   = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign div_out = (hi_reg || q_reg > q_lim) ? q_lim : (neg_reg ? (32'd0 - q_reg) : q_reg);

    assign tsum     = {first_stamp_reg[31], first_stamp_reg} + {1'b0, out_reg[6]};
    assign time_sat = (!tsum[32] && tsum[31]) ? 32'h7FFF_FFFF : tsum[31:0];
    assign fit_err  = ovf_reg || fail_reg;

    always_comb
    begin
        result_next.fit_x     = fit_err ? 32'sd0 : out_reg[0];
        result_next.fit_y     = fit_err ? 32'sd0 : out_reg[1];
        result_next.fit_z     = fit_err ? 32'sd0 : out_reg[2];
        result_next.vel_x     = fit_err ? 32'sd0 : out_reg[3];
        result_next.vel_y     = fit_err ? 32'sd0 : out_reg[4];
        result_next.vel_z     = fit_err ? 32'sd0 : out_reg[5];
        result_next.fit_time  = fit_err ? 32'sd0 : time_sat;
        result_next.fit_error = fit_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_RDA;
            pc_reg          <= CLEAR_PC;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            fail_reg        <= 1'b0;
            final_reg       <= 1'b0;
            done_reg        <= 1'b0;
            pp_vld_reg      <= 1'b0;
            first_stamp_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= point.pos_x;
                        y_reg     <= point.pos_y;
                        z_reg     <= point.pos_z;
                        v_reg     <= rel[14:2];
                        final_reg <= point.final_point;
                        if (count_reg == 5'd0)
                        begin
                            first_stamp_reg <= point.stamp;
                        end
                        if (drop)
                        begin
                            ovf_reg <= 1'b1;
                            if (point.final_point)
                            begin
                                pc_reg    <= SOLVE_PC;
                                state_reg <= S_RDA;
                            end
                        end
                        else
                        begin
                            count_reg <= count_reg + 5'd1;
                            pc_reg    <= ACC_PC;
                            state_reg <= S_RDA;
                        end
                    end
                end
                S_RDA:
                begin
                    if (ins.op == OP_ENDA)
                    begin
                        if (final_reg)
                        begin
                            pc_reg <= SOLVE_PC;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (ins.op == OP_ENDC)
                    begin
                        state_reg <= S_IDLE;
                        if (final_reg)
                        begin
                            done_reg        <= 1'b1;
                            result_reg      <= result_next;
                            count_reg       <= '0;
                            ovf_reg         <= 1'b0;
                            fail_reg        <= 1'b0;
                            final_reg       <= 1'b0;
                            first_stamp_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_RDB;
                    end
                end
                S_RDB:
                begin
                    a_reg     <= rdata;
                    state_reg <= S_OPB;
                end
                S_OPB:
                begin
                    case (ins.op)
                        OP_LD:
                        begin
                            res_reg   <= ld_val;
                            state_reg <= S_WB;
                        end
                        OP_ADD, OP_SUB:
                        begin
                            res_reg   <= sum[WORD_W-1:0];
                            state_reg <= S_WB;
                        end
                        OP_MUL:
                        begin
                            b_reg      <= rdata;
                            res_reg    <= '0;
                            i_reg      <= '0;
                            j_reg      <= '0;
                            pp_vld_reg <= 1'b0;
                            state_reg  <= S_MUL;
                        end
                        OP_DIV:
                        begin
                            b_reg     <= rdata;
                            res_reg   <= sum[WORD_W-1:0];
                            rem_reg   <= '0;
                            q_reg     <= '0;
                            hi_reg    <= 1'b0;
                            neg_reg   <= a_reg[WORD_W-1];
                            cnt_reg   <= '0;
                            state_reg <= S_DIV;
                        end
                        OP_CHK:
                        begin
                            if (a_reg[WORD_W-1] || a_reg == '0)
                            begin
                                fail_reg <= 1'b1;
                            end
                            state_reg <= S_WB;
                        end
                        default:
                        begin
                            state_reg <= S_WB;
                        end
                    endcase
                end
                S_MUL:
                begin
                    // Partial product is registered, then added in the following cycle.
                    pp_reg     <= a_limb * b_limb;
                    pp_sh_reg  <= 3'(i_reg + j_reg);
                    pp_vld_reg <= 1'b1;
                    if (pp_vld_reg)
                    begin
                        res_reg <= sum[WORD_W-1:0];
                    end
                    if (mul_wrap)
                    begin
                        i_reg <= i_reg + 3'd1;
                        j_reg <= '0;
                        if (i_reg == 3'(LIMBS - 1))
                        begin
                            state_reg <= S_MULD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 3'd1;
                    end
                end
                S_MULD:
                begin
                    res_reg    <= sum[WORD_W-1:0];
                    pp_vld_reg <= 1'b0;
                    state_reg  <= S_WB;
                end
                S_DIV:
                begin
                    res_reg <= {res_reg[WORD_W-2:0], 1'b0};
                    hi_reg  <= hi_reg | q_reg[31];
                    if (!sum[WORD_W])
                    begin
                        rem_reg <= sum[WORD_W-1:0];
                        q_reg   <= {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'(WORD_W - 1))
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (ins.op == OP_DIV)
                    begin
                        out_reg[ins.dst[2:0]] <= div_out;
                    end
                    pc_reg    <= pc_reg + 8'd1;
                    state_reg <= S_RDA;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while sequencer busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'(MAX_POINTS))
        else $error("point count beyond maximum");
    a_mul_limb: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL |-> i_reg < 3'(LIMBS))
        else $error("multiply limb index out of range");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.fit_error |-> result.fit_x == 0 && result.vel_z == 0 &&
        result.fit_time == 0)
        else $error("error result carries nonzero fields");
`endif

endmodule
`default_nettype wire
